// ----- design/date_to_utc_micros_defines.svh -----
// ----------------------------------------------------------------------------
// date_to_utc_micros_defines
// assertion macros shared by the date to utc conversion block
// ----------------------------------------------------------------------------
`ifndef DATE_TO_UTC_MICROS_DEFINES_SVH
`define DATE_TO_UTC_MICROS_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define DTU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtu check failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define DTU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtu check failed: next-cycle implication");

`endif

// ----- design/dtu_pkg.sv -----
// ----------------------------------------------------------------------------
// dtu_pkg
// widths, constants, types and the month table of the date to utc block
// ----------------------------------------------------------------------------
`default_nettype none

package dtu_pkg;

  // field widths
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int SIGN_W   = 2;
  localparam int ZONE_W   = 14;
  localparam int UTC_W    = 59;

  // internal widths
  localparam int DAYS_W = 24;
  localparam int TOD_W  = 28;

  // pipeline depth, sub-pipelines line up at stage four
  localparam int PIPE_DEPTH = 7;

  // zone sign codes
  localparam logic [SIGN_W-1:0] SIGN_PLUS  = 2'd0;
  localparam logic [SIGN_W-1:0] SIGN_MINUS = 2'd1;

  // calendar constants
  localparam int DAYS_PER_ERA  = 146097;
  localparam int EPOCH_SHIFT   = 719468;
  localparam int SECS_PER_DAY  = 86400;
  localparam int MICROS_ODD    = 15625;  // 1000000 = 15625 << 6

  // per-stage control travelling with the data
  typedef struct packed {
    logic vld;
    logic acc;
  } pipe_ctl_t;

  // days from march 1 to the first of the month, (153*mp+2)/5
  function automatic logic [8:0] month_base(input logic [MONTH_W-1:0] m);
    logic [8:0] v;
    unique case (m)
      4'd0:  v = 9'd275;
      4'd1:  v = 9'd306;
      4'd2:  v = 9'd337;
      4'd3:  v = 9'd0;
      4'd4:  v = 9'd31;
      4'd5:  v = 9'd61;
      4'd6:  v = 9'd92;
      4'd7:  v = 9'd122;
      4'd8:  v = 9'd153;
      4'd9:  v = 9'd184;
      4'd10: v = 9'd214;
      4'd11: v = 9'd245;
      4'd12: v = 9'd275;
      4'd13: v = 9'd306;
      4'd14: v = 9'd337;
      4'd15: v = 9'd367;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- design/dtu_days.sv -----
// ----------------------------------------------------------------------------
// dtu_days
// four-stage day count pipeline: era, year of era, day of era, days since 1970
// ----------------------------------------------------------------------------
`default_nettype none

module dtu_days import dtu_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [YEAR_W-1:0]          year,
  input  wire logic [MONTH_W-1:0]         month,
  input  wire logic [DAY_W-1:0]           day,
  output logic signed [DAYS_W-1:0]        days
);

  // stage 1: march-based year, era quotient product, day of year
  logic               jan_feb;
  logic signed [14:0] y_s;
  logic signed [14:0] s1_y_r;
  logic [15:0]        s1_eq_r, s1_eq_nxt;
  logic signed [9:0]  s1_doy_r, s1_doy_nxt;

  assign jan_feb    = (month <= 4'd2);
  assign y_s        = $signed({1'b0, year}) - $signed({14'd0, jan_feb});
  // y/400 = (y>>4)/25, and (x*41)>>10 is exact for x below 1024
  assign s1_eq_nxt  = 16'(y_s[13:4]) * 16'd41;
  assign s1_doy_nxt = $signed({1'b0, month_base(month)}) + $signed({5'd0, day}) - 10'sd1;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_y_r   <= y_s;
      s1_eq_r  <= s1_eq_nxt;
      s1_doy_r <= s1_doy_nxt;
    end
  end

  // stage 2: era and year of era, year -1 falls in era -1
  logic [5:0]        era_u;
  logic              y_neg;
  logic signed [6:0] s2_era_r, s2_era_nxt;
  logic [8:0]        s2_yoe_r, s2_yoe_nxt;
  logic signed [9:0] s2_doy_r;

  assign era_u      = s1_eq_r[15:10];
  assign y_neg      = s1_y_r[14];
  assign s2_era_nxt = y_neg ? -7'sd1 : $signed({1'b0, era_u});
  assign s2_yoe_nxt = y_neg ? 9'd399 : 9'(s1_y_r[13:0] - 14'(era_u) * 14'd400);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_era_r <= s2_era_nxt;
      s2_yoe_r <= s2_yoe_nxt;
      s2_doy_r <= s1_doy_r;
    end
  end

  // stage 3: day of era and era days
  logic [1:0]                cent;
  logic [17:0]               doe_u;
  logic signed [18:0]        s3_doe_r, s3_doe_nxt;
  logic signed [DAYS_W-1:0]  s3_era_days_r, s3_era_days_nxt;

  always_comb begin
    if (s2_yoe_r >= 9'd300) begin
      cent = 2'd3;
    end else if (s2_yoe_r >= 9'd200) begin
      cent = 2'd2;
    end else if (s2_yoe_r >= 9'd100) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
  end

  assign doe_u           = 18'(s2_yoe_r) * 18'd365 + 18'(s2_yoe_r[8:2]) - 18'(cent);
  assign s3_doe_nxt      = $signed({1'b0, doe_u}) + 19'(s2_doy_r);
  assign s3_era_days_nxt = DAYS_W'(s2_era_r) * DAYS_W'(DAYS_PER_ERA);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_doe_r      <= s3_doe_nxt;
      s3_era_days_r <= s3_era_days_nxt;
    end
  end

  // stage 4: days since 1970-01-01
  logic signed [DAYS_W-1:0] s4_days_r, s4_days_nxt;

  assign s4_days_nxt = s3_era_days_r + DAYS_W'(s3_doe_r) - DAYS_W'(EPOCH_SHIFT);

  always_ff @(posedge clk) begin
    if (en) begin
      s4_days_r <= s4_days_nxt;
    end
  end

  assign days = s4_days_r;

endmodule

`default_nettype wire

// ----- design/dtu_tod.sv -----
// ----------------------------------------------------------------------------
// dtu_tod
// four-stage time of day pipeline: local seconds of day minus zone offset
// ----------------------------------------------------------------------------
`default_nettype none

module dtu_tod import dtu_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [HOUR_W-1:0]       hour,
  input  wire logic [MINUTE_W-1:0]     minute,
  input  wire logic [SECOND_W-1:0]     second,
  input  wire logic [SIGN_W-1:0]       zone_sign,
  input  wire logic [ZONE_W-1:0]       zone_number,
  output logic signed [TOD_W-1:0]      tod
);

  // stage 1: local seconds, zone/100 product, offset format
  logic [16:0]       t1_hms_r, t1_hms_nxt;
  logic [22:0]       t1_zq_r, t1_zq_nxt;
  logic [ZONE_W-1:0] t1_zone_r;
  logic              t1_big_r, t1_minus_r;

  assign t1_hms_nxt = 17'(hour) * 17'd3600 + 17'(minute) * 17'd60 + 17'(second);
  // zone/100 = (zone>>2)/25, and (x*1311)>>15 is exact for x below 4096
  assign t1_zq_nxt  = 23'(zone_number[13:2]) * 23'd1311;

  always_ff @(posedge clk) begin
    if (en) begin
      t1_hms_r   <= t1_hms_nxt;
      t1_zq_r    <= t1_zq_nxt;
      t1_zone_r  <= zone_number;
      t1_big_r   <= (zone_number >= 14'd100);
      t1_minus_r <= (zone_sign == SIGN_MINUS);
    end
  end

  // stage 2: offset hours and minutes
  logic [7:0]        zq;
  logic [ZONE_W-1:0] zrem;
  logic [ZONE_W-1:0] t2_off_h_r, t2_off_h_nxt;
  logic [6:0]        t2_off_m_r, t2_off_m_nxt;
  logic [16:0]       t2_hms_r;
  logic              t2_minus_r;

  assign zq           = t1_zq_r[22:15];
  assign zrem         = t1_zone_r - 14'(zq) * 14'd100;
  assign t2_off_h_nxt = t1_big_r ? 14'(zq) : t1_zone_r;
  assign t2_off_m_nxt = t1_big_r ? zrem[6:0] : 7'd0;

  always_ff @(posedge clk) begin
    if (en) begin
      t2_off_h_r <= t2_off_h_nxt;
      t2_off_m_r <= t2_off_m_nxt;
      t2_hms_r   <= t1_hms_r;
      t2_minus_r <= t1_minus_r;
    end
  end

  // stage 3: offset in seconds
  logic [25:0] t3_off_r, t3_off_nxt;
  logic [16:0] t3_hms_r;
  logic        t3_minus_r;

  assign t3_off_nxt = 26'(t2_off_h_r) * 26'd3600 + 26'(t2_off_m_r) * 26'd60;

  always_ff @(posedge clk) begin
    if (en) begin
      t3_off_r   <= t3_off_nxt;
      t3_hms_r   <= t2_hms_r;
      t3_minus_r <= t2_minus_r;
    end
  end

  // stage 4: apply offset, a minus offset is added back
  logic signed [TOD_W-1:0] t4_tod_r, t4_tod_nxt;
  logic signed [TOD_W-1:0] hms_s, off_s;

  assign hms_s      = $signed({11'd0, t3_hms_r});
  assign off_s      = $signed({2'd0, t3_off_r});
  assign t4_tod_nxt = t3_minus_r ? (hms_s + off_s) : (hms_s - off_s);

  always_ff @(posedge clk) begin
    if (en) begin
      t4_tod_r <= t4_tod_nxt;
    end
  end

  assign tod = t4_tod_r;

endmodule

`default_nettype wire

// ----- design/date_to_utc_micros.sv -----
// ----------------------------------------------------------------------------
// date_to_utc_micros
// split local date and time with zone offset to utc microseconds since 1970
// ----------------------------------------------------------------------------
// Usage:
//   in_*  channel carries one date item (year, month, day, hour, minute,
//         second, zone sign and zone digits); out_* channel returns one
//         result item per input item, in order, as out_utc_micros and
//         out_valid_res. A zone sign other than plus or minus gives
//         out_valid_res 0 and out_utc_micros 0.
//   Throughput: one item per cycle while no stall holds the pipe. Depth:
//         seven register stages from acceptance to out_valid (four for day count
//         and time of day in parallel, then seconds of day, seconds total,
//         and the microsecond multiply into the output register).
//   Stall: when out_valid is high and out_ready low, the whole pipeline
//         holds and in_ready drops in the same cycle; nothing is lost or
//         repeated, and the pipe resumes the cycle out_ready returns.
//   Reset: rst_n low (synchronous) clears all stage valid bits; the pipe is
//         empty and ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "date_to_utc_micros_defines.svh"

module date_to_utc_micros import dtu_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [YEAR_W-1:0]        in_year,
  input  wire logic [MONTH_W-1:0]       in_month,
  input  wire logic [DAY_W-1:0]         in_day,
  input  wire logic [HOUR_W-1:0]        in_hour,
  input  wire logic [MINUTE_W-1:0]      in_minute,
  input  wire logic [SECOND_W-1:0]      in_second,
  input  wire logic [SIGN_W-1:0]        in_zone_sign,
  input  wire logic [ZONE_W-1:0]        in_zone_number,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [UTC_W-1:0]       out_utc_micros,
  output logic                          out_valid_res
);

  // global advance: the pipe moves unless a finished item waits
  logic      en;
  pipe_ctl_t ctl_r [1:PIPE_DEPTH];
  pipe_ctl_t ctl_in;

  assign en       = !ctl_r[PIPE_DEPTH].vld || out_ready;
  assign in_ready = en;

  assign ctl_in.vld = in_valid;
  assign ctl_in.acc = (in_zone_sign == SIGN_PLUS) || (in_zone_sign == SIGN_MINUS);

  // control shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= PIPE_DEPTH; i++) begin
        ctl_r[i] <= '0;
      end
    end else if (en) begin
      ctl_r[1] <= ctl_in;
      for (int i = 2; i <= PIPE_DEPTH; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  // stages 1-4: day count and time of day side by side
  logic signed [DAYS_W-1:0] days;
  logic signed [TOD_W-1:0]  tod;

  dtu_days u_days (
    .clk   (clk),
    .en    (en),
    .year  (in_year),
    .month (in_month),
    .day   (in_day),
    .days  (days)
  );

  dtu_tod u_tod (
    .clk         (clk),
    .en          (en),
    .hour        (in_hour),
    .minute      (in_minute),
    .second      (in_second),
    .zone_sign   (in_zone_sign),
    .zone_number (in_zone_number),
    .tod         (tod)
  );

  // stage 5: seconds of the day count
  logic signed [40:0]      s5_secs_day_r, s5_secs_day_nxt;
  logic signed [TOD_W-1:0] s5_tod_r;

  assign s5_secs_day_nxt = 41'(days) * 41'(SECS_PER_DAY);

  always_ff @(posedge clk) begin
    if (en) begin
      s5_secs_day_r <= s5_secs_day_nxt;
      s5_tod_r      <= tod;
    end
  end

  // stage 6: total utc seconds
  logic signed [41:0] s6_secs_r, s6_secs_nxt;

  assign s6_secs_nxt = 42'(s5_secs_day_r) + 42'(s5_tod_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s6_secs_r <= s6_secs_nxt;
    end
  end

  // stage 7: microseconds, low bits only, times 15625 then shift by 6, zero when rejected
  logic signed [52:0]      micros_odd;
  logic signed [UTC_W-1:0] s7_micros_r, s7_micros_nxt;

  assign micros_odd    = 53'(s6_secs_r) * 53'(MICROS_ODD);
  assign s7_micros_nxt = ctl_r[PIPE_DEPTH-1].acc ? $signed({micros_odd, 6'd0}) : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_micros_r <= s7_micros_nxt;
    end
  end

  assign out_valid      = ctl_r[PIPE_DEPTH].vld;
  assign out_valid_res  = ctl_r[PIPE_DEPTH].acc;
  assign out_utc_micros = s7_micros_r;

  // checks
  `DTU_ASSERT_NOW(a_reject_zero, clk, rst_n, out_valid && !out_valid_res, out_utc_micros == '0)
  `DTU_ASSERT_NOW(a_stall_blocks_in, clk, rst_n, out_valid && !out_ready, !in_ready)
  `DTU_ASSERT_NOW(a_drain_opens_in, clk, rst_n, out_ready, in_ready)
  `DTU_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_valid && in_ready, ctl_r[1].vld)

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the date to utc block: date items go in over a valid/ready channel,
// each one is run through a local utc predictor, and every returned
// item is compared in order against the oldest predicted result.
// ----------------------------------------------------------------------------

module tb_top;
  import dtu_pkg::*;

  // sign codes the block must reject
  localparam logic [SIGN_W-1:0] SIGN_OTHER = 2'd2;
  localparam logic [SIGN_W-1:0] SIGN_STRAY = 2'd3;

  localparam int PHASE_ITEMS = 134;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic [SIGN_W-1:0]   zone_sign;
    logic [ZONE_W-1:0]   zone_number;
  } date_item_t;

  typedef struct packed {
    logic [UTC_W-1:0] micros;
    logic             accepted;
  } utc_result_t;

  // predicts utc microseconds for each accepted date and checks results in order
  class utc_scoreboard;
    utc_result_t pending_utc_q[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    function utc_result_t utc_from_local(date_item_t d);
      longint y, m, dd, era, yoe, mp, doy, doe, days;
      longint hh, mi, ss, zn, off_h, off_m, secs;
      utc_result_t r;
      r.micros   = '0;
      r.accepted = 1'b0;
      if (d.zone_sign != SIGN_PLUS && d.zone_sign != SIGN_MINUS) return r;
      y  = d.year;
      m  = d.month;
      dd = d.day;
      hh = d.hour;
      mi = d.minute;
      ss = d.second;
      zn = d.zone_number;
      // year starts in march, so jan and feb belong to the year before
      if (m <= 2) y = y - 1;
      era  = (y >= 0 ? y : y - 399) / 400;
      yoe  = y - era * 400;
      mp   = (m > 2) ? m - 3 : m + 9;
      doy  = (153 * mp + 2) / 5 + dd - 1;
      doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days = era * DAYS_PER_ERA + doe - EPOCH_SHIFT;
      // zone digits: hhmm from 100 up, plain hours below
      if (zn >= 100) begin
        off_h = zn / 100;
        off_m = zn % 100;
      end else begin
        off_h = zn;
        off_m = 0;
      end
      if (d.zone_sign == SIGN_MINUS) begin
        off_h = -off_h;
        off_m = -off_m;
      end
      secs = days * SECS_PER_DAY + hh * 3600 + mi * 60 + ss;
      secs = secs - (off_h * 3600 + off_m * 60);
      r.micros   = UTC_W'(secs * 64'sd1000000);
      r.accepted = 1'b1;
      return r;
    endfunction

    function void note_date(date_item_t d);
      pending_utc_q.push_back(utc_from_local(d));
    endfunction

    function void check_result(logic [UTC_W-1:0] micros, logic accepted);
      utc_result_t exp_r;
      if (pending_utc_q.size() == 0) begin
        $error("unexpected result item: utc_micros %0d valid_res %0b",
               $signed(micros), accepted);
        errors++;
        return;
      end
      exp_r = pending_utc_q.pop_front();
      if (micros !== exp_r.micros) begin
        $error("utc_micros: expected %0d actual %0d",
               $signed(exp_r.micros), $signed(micros));
        errors++;
      end
      if (accepted !== exp_r.accepted) begin
        $error("valid_res: expected %0b actual %0b", exp_r.accepted, accepted);
        errors++;
      end
    endfunction

    function int pending();
      return pending_utc_q.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [YEAR_W-1:0]          in_year;
  logic [MONTH_W-1:0]         in_month;
  logic [DAY_W-1:0]           in_day;
  logic [HOUR_W-1:0]          in_hour;
  logic [MINUTE_W-1:0]        in_minute;
  logic [SECOND_W-1:0]        in_second;
  logic [SIGN_W-1:0]          in_zone_sign;
  logic [ZONE_W-1:0]          in_zone_number;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [UTC_W-1:0]    out_utc_micros;
  logic                       out_valid_res;

  utc_scoreboard sb;
  int            in_idle_pct;
  int            out_stall_pct;

  date_to_utc_micros u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_year        (in_year),
    .in_month       (in_month),
    .in_day         (in_day),
    .in_hour        (in_hour),
    .in_minute      (in_minute),
    .in_second      (in_second),
    .in_zone_sign   (in_zone_sign),
    .in_zone_number (in_zone_number),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_utc_micros (out_utc_micros),
    .out_valid_res  (out_valid_res)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side: check accepted items, then stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_utc_micros, out_valid_res);
    end
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // run limit
  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

  function automatic date_item_t mk_date(int y, int mo, int d, int h, int mi, int s,
                                         logic [SIGN_W-1:0] sg, int z);
    date_item_t it;
    it.year        = YEAR_W'(y);
    it.month       = MONTH_W'(mo);
    it.day         = DAY_W'(d);
    it.hour        = HOUR_W'(h);
    it.minute      = MINUTE_W'(mi);
    it.second      = SECOND_W'(s);
    it.zone_sign   = sg;
    it.zone_number = ZONE_W'(z);
    return it;
  endfunction

  function automatic date_item_t random_date();
    date_item_t it;
    // raw bit patterns, out-of-range fields included
    if ($urandom_range(99) < 15) begin
      it.year        = YEAR_W'($urandom);
      it.month       = MONTH_W'($urandom);
      it.day         = DAY_W'($urandom);
      it.hour        = HOUR_W'($urandom);
      it.minute      = MINUTE_W'($urandom);
      it.second      = SECOND_W'($urandom);
      it.zone_sign   = SIGN_W'($urandom);
      it.zone_number = ZONE_W'($urandom);
      return it;
    end
    // date and time fields in range, day up to 31 in any month
    it.year   = YEAR_W'($urandom_range(9999));
    it.month  = MONTH_W'($urandom_range(12, 1));
    it.day    = ($urandom_range(9) == 0) ? DAY_W'($urandom_range(31, 29))
                                         : DAY_W'($urandom_range(28, 1));
    it.hour   = HOUR_W'($urandom_range(23));
    it.minute = MINUTE_W'($urandom_range(59));
    it.second = ($urandom_range(19) == 0) ? SECOND_W'(60) : SECOND_W'($urandom_range(59));
    case ($urandom_range(19))
      0:       it.zone_sign = SIGN_OTHER;
      1:       it.zone_sign = SIGN_STRAY;
      default: it.zone_sign = $urandom_range(1) ? SIGN_MINUS : SIGN_PLUS;
    endcase
    case ($urandom_range(2))
      0:       it.zone_number = ZONE_W'($urandom_range(99));
      1:       it.zone_number = ZONE_W'($urandom_range(14) * 100 + $urandom_range(59));
      default: it.zone_number = ZONE_W'($urandom_range(9999));
    endcase
    return it;
  endfunction

  // present one item, hold it until accepted, then record it
  task automatic send_date(input date_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_year        <= it.year;
    in_month       <= it.month;
    in_day         <= it.day;
    in_hour        <= it.hour;
    in_minute      <= it.minute;
    in_second      <= it.second;
    in_zone_sign   <= it.zone_sign;
    in_zone_number <= it.zone_number;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_date(it);
  endtask

  initial begin
    date_item_t directed_q[$];
    sb = new();
    in_idle_pct   = 24;
    out_stall_pct = 56;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_year        <= '0;
    in_month       <= '0;
    in_day         <= '0;
    in_hour        <= '0;
    in_minute      <= '0;
    in_second      <= '0;
    in_zone_sign   <= SIGN_PLUS;
    in_zone_number <= '0;
    out_ready      <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items: epoch, extremes, zone forms, leap cases, rejected signs
    directed_q.push_back(mk_date(1970, 1, 1, 0, 0, 0, SIGN_PLUS, 0));
    directed_q.push_back(mk_date(1969, 12, 31, 23, 59, 59, SIGN_PLUS, 0));
    directed_q.push_back(mk_date(0, 1, 1, 0, 0, 0, SIGN_PLUS, 0));
    directed_q.push_back(mk_date(0, 2, 29, 12, 0, 0, SIGN_MINUS, 5));
    directed_q.push_back(mk_date(0, 3, 1, 0, 0, 0, SIGN_PLUS, 1));
    directed_q.push_back(mk_date(9999, 12, 31, 23, 59, 60, SIGN_MINUS, 9999));
    directed_q.push_back(mk_date(2000, 2, 29, 12, 34, 56, SIGN_PLUS, 530));
    directed_q.push_back(mk_date(1900, 3, 1, 6, 7, 8, SIGN_MINUS, 99));
    directed_q.push_back(mk_date(2024, 6, 15, 18, 30, 0, SIGN_PLUS, 100));
    directed_q.push_back(mk_date(2016, 12, 31, 23, 59, 60, SIGN_PLUS, 0));
    directed_q.push_back(mk_date(400, 1, 1, 0, 0, 0, SIGN_PLUS, 14));
    directed_q.push_back(mk_date(2021, 7, 4, 9, 15, 30, SIGN_OTHER, 200));
    directed_q.push_back(mk_date(2021, 7, 4, 9, 15, 30, SIGN_STRAY, 16383));
    directed_q.push_back(mk_date(2001, 0, 0, 0, 0, 0, SIGN_PLUS, 0));
    directed_q.push_back(mk_date(2001, 13, 31, 0, 0, 0, SIGN_MINUS, 1259));
    directed_q.push_back(mk_date(1999, 14, 10, 0, 0, 0, SIGN_PLUS, 99));
    directed_q.push_back(mk_date(16383, 15, 31, 31, 63, 63, SIGN_MINUS, 16383));
    directed_q.push_back(mk_date(16383, 15, 31, 31, 63, 63, SIGN_PLUS, 16383));
    directed_q.push_back(mk_date(0, 0, 0, 0, 0, 0, SIGN_PLUS, 0));
    directed_q.push_back(mk_date(0, 0, 0, 0, 0, 0, SIGN_MINUS, 16383));
    directed_q.push_back(mk_date(1600, 2, 29, 23, 0, 0, SIGN_MINUS, 1200));
    foreach (directed_q[i]) send_date(directed_q[i]);

    // hold off until the pipe has drained
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);

    // random items over three idling profiles
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          in_idle_pct   = 24;
          out_stall_pct = 56;
        end
        1: begin
          in_idle_pct   = 56;
          out_stall_pct = 24;
        end
        default: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end
      endcase
      repeat (PHASE_ITEMS) send_date(random_date());
    end
    in_valid <= 1'b0;

    // drain, then allow for stray items
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
